// ===== rtl/hcbd_pkg.sv =====
// Shared types, codes and constants of the chunked HTTP body decoder.
package hcbd_pkg;

  localparam int unsigned DefCountWidth = 32;
  localparam int unsigned DefSizeWidth  = 64;

  localparam logic [31:0] MaxDecodedReset = 32'd16777216;
  localparam logic [31:0] MaxRawReset     = 32'd33554432;

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_SEMI = 8'h3B;

  typedef enum logic [1:0] {
    FN_BYTE  = 2'd0,
    FN_NEW   = 2'd1,
    FN_CLOSE = 2'd2
  } fn_e;

  typedef enum logic [2:0] {
    ST_PROGRESS  = 3'd0,
    ST_COMPLETE  = 3'd1,
    ST_INVALID   = 3'd2,
    ST_TOO_LARGE = 3'd3,
    ST_CLOSED    = 3'd4
  } st_e;

  typedef enum logic [3:0] {
    PH_LEAD    = 4'd0,
    PH_HEX     = 4'd1,
    PH_TRAIL   = 4'd2,
    PH_EXT     = 4'd3,
    PH_DATA    = 4'd4,
    PH_DATA_CR = 4'd5,
    PH_DATA_LF = 4'd6,
    PH_TRAILER = 4'd7,
    PH_DONE    = 4'd8
  } ph_e;

  localparam logic REG_MAX_DECODED = 1'b0;
  localparam logic REG_MAX_RAW     = 1'b1;

  // Returns the hex digit value in the low four bits and a valid flag on top.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

// ===== rtl/hcbd_if.sv =====
// Request channel interfaces for the decoder input and result streams.
interface hcbd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] in_byte;

  modport source (output valid, func, in_byte, input ready);
  modport sink (input valid, func, in_byte, output ready);
endinterface

interface hcbd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic [2:0] status;

  modport source (output valid, out_byte, out_valid, status, input ready);
  modport sink (input valid, out_byte, out_valid, status, output ready);
endinterface

// ===== rtl/http_chunked_body_decoder.sv =====
// Top level of the chunked HTTP body decoder with its APB limit registers.
// A request is held in the input register and then in the result register, which drives the result port.
// Throughput: one request per cycle while the result port is ready; the per-byte parse step sits between the
// input register and the result register, so the parse state loop sets the rate.
// Reset clears the parse state and the input and result valid flags and loads the default limits;
// there is no clearing pass.
module http_chunked_body_decoder
  import hcbd_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = DefCountWidth,
  parameter int unsigned SIZE_WIDTH  = DefSizeWidth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hcbd_in_if.sink     in_i,
  hcbd_out_if.source  out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned CmpW = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;

  logic [31:0] max_dec_q, max_raw_q;

  logic       in_vld_q;
  logic [1:0] in_func_q;
  logic [7:0] in_byte_q;

  logic       out_vld_q;
  logic [7:0] out_byte_q;
  logic       out_pay_q;
  st_e        out_st_q;

  ph_e                    ph_q, ph_d;
  logic [SIZE_WIDTH-1:0]  chunk_q, chunk_d;
  logic                   digit_q, digit_d;
  logic                   cr_q, cr_d;
  logic                   lie_q, lie_d;
  logic [COUNT_WIDTH-1:0] dec_q, dec_d;
  logic [COUNT_WIDTH-1:0] raw_q, raw_d;
  st_e                    st_q, st_d;
  logic                   pay_vld;
  logic [4:0]             hex;
  logic                   advance;
  logic                   cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_MAX_RAW) ? max_raw_q : max_dec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_dec_q <= MaxDecodedReset;
      max_raw_q <= MaxRawReset;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_MAX_RAW) begin
        max_raw_q <= pwdata;
      end else begin
        max_dec_q <= pwdata;
      end
    end
  end

  assign advance    = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_func_q <= in_i.func;
      in_byte_q <= in_i.in_byte;
    end
    if (advance) begin
      out_byte_q <= pay_vld ? in_byte_q : 8'd0;
      out_pay_q  <= pay_vld;
      out_st_q   <= st_d;
    end
  end

  assign hex = hex_digit(in_byte_q);

  always_comb begin
    ph_d    = ph_q;
    chunk_d = chunk_q;
    digit_d = digit_q;
    cr_d    = cr_q;
    lie_d   = lie_q;
    dec_d   = dec_q;
    raw_d   = raw_q;
    st_d    = st_q;
    pay_vld = 1'b0;
    if (advance) begin
      case (in_func_q)
        FN_NEW: begin
          ph_d    = PH_LEAD;
          chunk_d = '0;
          digit_d = 1'b0;
          cr_d    = 1'b0;
          lie_d   = 1'b1;
          dec_d   = '0;
          raw_d   = '0;
          st_d    = ST_PROGRESS;
        end
        FN_CLOSE: begin
          if (st_q == ST_PROGRESS) begin
            st_d = ST_CLOSED;
            ph_d = PH_DONE;
          end
        end
        FN_BYTE: begin
          if (st_q == ST_PROGRESS) begin
            if (raw_q != '1) begin
              raw_d = raw_q + COUNT_WIDTH'(1);
            end
            case (ph_q)
              PH_LEAD, PH_HEX, PH_TRAIL: begin
                if (cr_q) begin
                  cr_d = 1'b0;
                  if (in_byte_q != CH_LF || !digit_q) begin
                    st_d = ST_INVALID;
                    ph_d = PH_DONE;
                  end else if (chunk_q == '0) begin
                    ph_d  = PH_TRAILER;
                    lie_d = 1'b1;
                  end else begin
                    ph_d = PH_DATA;
                  end
                end else if (in_byte_q == CH_CR) begin
                  cr_d = 1'b1;
                end else if (in_byte_q == CH_SP || in_byte_q == CH_TAB) begin
                  if (ph_q == PH_HEX) begin
                    ph_d = PH_TRAIL;
                  end
                end else if (in_byte_q == CH_SEMI) begin
                  if (!digit_q) begin
                    st_d = ST_INVALID;
                    ph_d = PH_DONE;
                  end else begin
                    ph_d = PH_EXT;
                  end
                end else if (!hex[4] || ph_q == PH_TRAIL ||
                             chunk_q[SIZE_WIDTH-1 -: 4] != 4'd0) begin
                  st_d = ST_INVALID;
                  ph_d = PH_DONE;
                end else begin
                  chunk_d = {chunk_q[SIZE_WIDTH-5:0], hex[3:0]};
                  digit_d = 1'b1;
                  ph_d    = PH_HEX;
                end
              end
              PH_EXT: begin
                if (cr_q && in_byte_q == CH_LF) begin
                  cr_d = 1'b0;
                  if (!digit_q) begin
                    st_d = ST_INVALID;
                    ph_d = PH_DONE;
                  end else if (chunk_q == '0) begin
                    ph_d  = PH_TRAILER;
                    lie_d = 1'b1;
                  end else begin
                    ph_d = PH_DATA;
                  end
                end else begin
                  cr_d = (in_byte_q == CH_CR);
                end
              end
              PH_DATA: begin
                pay_vld = 1'b1;
                chunk_d = chunk_q - SIZE_WIDTH'(1);
                if (chunk_q == SIZE_WIDTH'(1)) begin
                  ph_d = PH_DATA_CR;
                end
              end
              PH_DATA_CR: begin
                if (in_byte_q == CH_CR) begin
                  ph_d = PH_DATA_LF;
                end else begin
                  st_d = ST_INVALID;
                  ph_d = PH_DONE;
                end
              end
              PH_DATA_LF: begin
                if (in_byte_q == CH_LF) begin
                  ph_d    = PH_LEAD;
                  chunk_d = '0;
                  digit_d = 1'b0;
                  cr_d    = 1'b0;
                end else begin
                  st_d = ST_INVALID;
                  ph_d = PH_DONE;
                end
              end
              PH_TRAILER: begin
                if (cr_q && in_byte_q == CH_LF) begin
                  cr_d = 1'b0;
                  if (lie_q) begin
                    st_d = ST_COMPLETE;
                    ph_d = PH_DONE;
                  end else begin
                    lie_d = 1'b1;
                  end
                end else if (in_byte_q == CH_CR) begin
                  cr_d = 1'b1;
                  if (cr_q) begin
                    lie_d = 1'b0;
                  end
                end else begin
                  cr_d  = 1'b0;
                  lie_d = 1'b0;
                end
              end
              default: begin
              end
            endcase
            if (pay_vld && dec_q != '1) begin
              dec_d = dec_q + COUNT_WIDTH'(1);
            end
            if (st_d == ST_PROGRESS &&
                (CmpW'(dec_d) > CmpW'(max_dec_q) || CmpW'(raw_d) > CmpW'(max_raw_q))) begin
              st_d = ST_TOO_LARGE;
              ph_d = PH_DONE;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q    <= PH_LEAD;
      chunk_q <= '0;
      digit_q <= 1'b0;
      cr_q    <= 1'b0;
      lie_q   <= 1'b1;
      dec_q   <= '0;
      raw_q   <= '0;
      st_q    <= ST_PROGRESS;
    end else begin
      ph_q    <= ph_d;
      chunk_q <= chunk_d;
      digit_q <= digit_d;
      cr_q    <= cr_d;
      lie_q   <= lie_d;
      dec_q   <= dec_d;
      raw_q   <= raw_d;
      st_q    <= st_d;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.out_byte  = out_byte_q;
  assign out_o.out_valid = out_pay_q;
  assign out_o.status    = out_st_q;

  // The parser sits in its done phase exactly when the body has a final status.
  a_done_matches_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ph_q == PH_DONE) == (st_q != ST_PROGRESS))
    else $error("done phase and final status disagree");

  // A payload byte is only ever reported while in progress or on the limit crossing.
  a_payload_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_pay_q) |-> (out_st_q == ST_PROGRESS || out_st_q == ST_TOO_LARGE))
    else $error("payload byte reported with a final status");

  // The input side stalls only when both the input and result registers are held.
  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (in_vld_q && out_vld_q && !out_o.ready))
    else $error("input stalled without a full pipeline");

  // A request moved into the result register leaves the input register empty
  // unless a new one was taken in the same cycle.
  a_advance_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !in_i.valid) |=> !in_vld_q)
    else $error("input register not drained after advance");

endmodule

// ===== bench/http_chunked_body_decoder_tb.sv =====
// Self-checking testbench for the chunked HTTP body decoder with random traffic and limits.
module http_chunked_body_decoder_tb;
  import hcbd_pkg::*;

  localparam logic [1:0] FnUndef = 2'd3;
  localparam int NumPhases = 5;
  localparam int HoldCycles = 400;
  localparam logic [31:0] PhaseDecLimit [NumPhases] =
    '{32'hFFFF_FFFF, 32'd24, 32'd0, 32'd40, 32'hFFFF_FFFF};
  localparam logic [31:0] PhaseRawLimit [NumPhases] =
    '{32'hFFFF_FFFF, 32'd80, 32'hFFFF_FFFF, 32'd200, 32'd0};
  localparam int PhaseSendIdle [NumPhases] = '{0, 52, 0, 17, 0};
  localparam int PhaseRecvStall [NumPhases] = '{0, 0, 52, 17, 0};
  localparam int PhaseItems [NumPhases] = '{350, 350, 250, 300, 60};

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data;
  } body_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    st_e        status;
  } decoded_t;

  logic        clk;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  hcbd_in_if  req_if ();
  hcbd_out_if rsp_if ();

  http_chunked_body_decoder i_dut (
    .clk_i   (clk),
    .rst_ni  (rst_ni),
    .in_i    (req_if),
    .out_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  body_req_t  pending_q [$];
  decoded_t   decoded_q [$];
  body_req_t  next_req;
  decoded_t   head;
  logic       req_taken;
  int         send_idle_pct;
  int         recv_stall_pct;
  int         hold_left;
  logic       hold_start;
  int         mismatches;
  int         queued;

  // Predictor state.
  ph_e         parse_ph;
  logic [63:0] size_left;
  logic        digit_seen;
  logic        cr_pend;
  logic        line_empty;
  logic [31:0] dec_cnt;
  logic [31:0] raw_cnt;
  st_e         body_st;
  logic [31:0] lim_dec;
  logic [31:0] lim_raw;

  function automatic int hex_val(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 48;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 87;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 55;
    return -1;
  endfunction

  function automatic void clear_body();
    parse_ph = PH_LEAD;
    size_left = '0;
    digit_seen = 1'b0;
    cr_pend = 1'b0;
    line_empty = 1'b1;
    dec_cnt = '0;
    raw_cnt = '0;
    body_st = ST_PROGRESS;
  endfunction

  function automatic void reject_body();
    body_st = ST_INVALID;
    parse_ph = PH_DONE;
  endfunction

  function automatic void close_size_line();
    cr_pend = 1'b0;
    if (!digit_seen) begin
      reject_body();
    end else if (size_left == 0) begin
      parse_ph = PH_TRAILER;
      line_empty = 1'b1;
    end else begin
      parse_ph = PH_DATA;
    end
  endfunction

  // Advances the parser by one encoded byte and tells whether it is payload.
  function automatic logic parse_byte(input logic [7:0] c);
    int hv;
    logic payload;
    payload = 1'b0;
    case (parse_ph)
      PH_LEAD, PH_HEX, PH_TRAIL: begin
        if (cr_pend) begin
          if (c == CH_LF) close_size_line();
          else reject_body();
        end else if (c == CH_CR) begin
          cr_pend = 1'b1;
        end else if (c == CH_SP || c == CH_TAB) begin
          if (parse_ph == PH_HEX) parse_ph = PH_TRAIL;
        end else if (c == CH_SEMI) begin
          if (!digit_seen) reject_body();
          else parse_ph = PH_EXT;
        end else begin
          hv = hex_val(c);
          if (hv < 0 || parse_ph == PH_TRAIL || size_left[63:60] != 4'd0) begin
            reject_body();
          end else begin
            size_left = {size_left[59:0], hv[3:0]};
            digit_seen = 1'b1;
            parse_ph = PH_HEX;
          end
        end
      end
      PH_EXT: begin
        if (cr_pend && c == CH_LF) close_size_line();
        else cr_pend = (c == CH_CR);
      end
      PH_DATA: begin
        size_left = size_left - 64'd1;
        if (size_left == 0) parse_ph = PH_DATA_CR;
        payload = 1'b1;
      end
      PH_DATA_CR: begin
        if (c == CH_CR) parse_ph = PH_DATA_LF;
        else reject_body();
      end
      PH_DATA_LF: begin
        if (c == CH_LF) begin
          parse_ph = PH_LEAD;
          size_left = '0;
          digit_seen = 1'b0;
          cr_pend = 1'b0;
        end else begin
          reject_body();
        end
      end
      PH_TRAILER: begin
        if (cr_pend && c == CH_LF) begin
          cr_pend = 1'b0;
          if (line_empty) begin
            body_st = ST_COMPLETE;
            parse_ph = PH_DONE;
          end else begin
            line_empty = 1'b1;
          end
        end else begin
          if (cr_pend) line_empty = 1'b0;
          if (c == CH_CR) begin
            cr_pend = 1'b1;
          end else begin
            cr_pend = 1'b0;
            line_empty = 1'b0;
          end
        end
      end
      default: ;
    endcase
    return payload;
  endfunction

  function automatic void decode_step(input logic [1:0] fn, input logic [7:0] c);
    logic payload;
    decoded_t res;
    payload = 1'b0;
    if (fn == FN_NEW) begin
      clear_body();
    end else if (fn == FN_CLOSE) begin
      if (body_st == ST_PROGRESS) begin
        body_st = ST_CLOSED;
        parse_ph = PH_DONE;
      end
    end else if (fn == FN_BYTE && body_st == ST_PROGRESS) begin
      if (raw_cnt != '1) raw_cnt = raw_cnt + 32'd1;
      payload = parse_byte(c);
      if (payload && dec_cnt != '1) dec_cnt = dec_cnt + 32'd1;
      if (body_st == ST_PROGRESS && (dec_cnt > lim_dec || raw_cnt > lim_raw)) begin
        body_st = ST_TOO_LARGE;
        parse_ph = PH_DONE;
      end
    end
    res.out_byte = payload ? c : 8'h00;
    res.out_valid = payload;
    res.status = body_st;
    decoded_q = {decoded_q, res};
  endfunction

  task automatic push_item(input logic [1:0] fn, input logic [7:0] b);
    body_req_t r;
    r.func = fn;
    r.data = b;
    pending_q = {pending_q, r};
    queued++;
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) push_item(FN_BYTE, s[i]);
  endtask

  function automatic logic [7:0] rand_ws();
    return $urandom_range(1) ? CH_SP : CH_TAB;
  endfunction

  function automatic logic [7:0] rand_text();
    return 8'($urandom_range(32, 126));
  endfunction

  function automatic logic [7:0] rand_hex_digit();
    string digits;
    digits = "0123456789abcdefABCDEF";
    return digits[$urandom_range(21)];
  endfunction

  // A well-formed body with random content, sometimes damaged or cut short.
  task automatic gen_body();
    logic [7:0] q [$];
    int n_chunks;
    int size;
    int pos;
    int kind;
    string hex;
    n_chunks = $urandom_range(0, 3);
    for (int k = 0; k <= n_chunks; k++) begin
      if (k == n_chunks) size = 0;
      else if ($urandom_range(7) == 0) size = $urandom_range(17, 40);
      else size = $urandom_range(1, 8);
      repeat ($urandom_range(2)) q = {q, rand_ws()};
      repeat ($urandom_range(2)) q = {q, 8'h30};
      hex = $sformatf("%0h", size);
      for (int i = 0; i < hex.len(); i++) begin
        if (hex[i] >= 8'h61 && $urandom_range(1)) q = {q, 8'(hex[i] - 8'h20)};
        else q = {q, hex[i]};
      end
      repeat ($urandom_range(2)) q = {q, rand_ws()};
      if ($urandom_range(3) == 0) begin
        q = {q, CH_SEMI};
        repeat ($urandom_range(4)) begin
          if ($urandom_range(3) == 0) q = {q, 8'($urandom)};
          else q = {q, rand_text()};
        end
      end
      q = {q, CH_CR};
      q = {q, CH_LF};
      repeat (size) q = {q, 8'($urandom)};
      if (size != 0) begin
        q = {q, CH_CR};
        q = {q, CH_LF};
      end
    end
    repeat ($urandom_range(2)) begin
      repeat ($urandom_range(1, 5)) q = {q, rand_text()};
      q = {q, CH_CR};
      q = {q, CH_LF};
    end
    q = {q, CH_CR};
    q = {q, CH_LF};
    kind = $urandom_range(9);
    pos = $urandom_range(q.size() - 1);
    case (kind)
      0: q[pos] = 8'($urandom);
      1: q.delete(pos);
      2: q.insert(pos, 8'($urandom));
      3: q = q[0:pos];
      default: ;
    endcase
    push_item(FN_NEW, 8'($urandom));
    foreach (q[i]) push_item(FN_BYTE, q[i]);
    if (kind == 3 || $urandom_range(7) == 0) push_item(FN_CLOSE, 8'($urandom));
    if ($urandom_range(9) == 0) push_item(FnUndef, 8'($urandom));
    if ($urandom_range(5) == 0) begin
      repeat ($urandom_range(1, 3)) push_item(FN_BYTE, 8'($urandom));
    end
  endtask

  // A size line near or past the 64-bit size range.
  task automatic gen_long_size();
    push_item(FN_NEW, 8'($urandom));
    push_item(FN_BYTE, 8'h31);
    repeat ($urandom_range(15, 17)) push_item(FN_BYTE, rand_hex_digit());
    push_item(FN_BYTE, CH_CR);
    push_item(FN_BYTE, CH_LF);
    repeat ($urandom_range(1, 4)) push_item(FN_BYTE, 8'($urandom));
    push_item(FN_CLOSE, 8'($urandom));
  endtask

  task automatic gen_noise();
    push_item(FN_NEW, 8'($urandom));
    repeat ($urandom_range(1, 6)) begin
      if ($urandom_range(3) == 0) push_item(2'($urandom), 8'($urandom));
      else push_item(FN_BYTE, 8'($urandom));
    end
  endtask

  task automatic gen_items(input int n);
    int target;
    int pick;
    target = queued + n;
    while (queued < target) begin
      pick = $urandom_range(19);
      if (pick == 0) gen_long_size();
      else if (pick < 3) gen_noise();
      else gen_body();
    end
  endtask

  task automatic set_limit(input logic reg_idx, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (reg_idx == REG_MAX_DECODED) lim_dec = value;
    else lim_raw = value;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== value) begin
      $display("%0t: register %0d readback, expected %08h, got %08h",
               $time, reg_idx, value, prdata);
      mismatches++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || req_if.valid || decoded_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(4 * 400000);
    $display("Mismatches found");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_ni && req_if.valid && req_if.ready) begin
      decode_step(req_if.func, req_if.in_byte);
      req_taken = 1'b1;
    end
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got byte %02h valid %0b status %0d",
                 $time, rsp_if.out_byte, rsp_if.out_valid, rsp_if.status);
        mismatches++;
      end else begin
        head = decoded_q.pop_front();
        if (rsp_if.out_byte !== head.out_byte) begin
          $display("%0t: out_byte mismatch, expected %02h, got %02h",
                   $time, head.out_byte, rsp_if.out_byte);
          mismatches++;
        end
        if (rsp_if.out_valid !== head.out_valid) begin
          $display("%0t: out_valid mismatch, expected %0b, got %0b",
                   $time, head.out_valid, rsp_if.out_valid);
          mismatches++;
        end
        if (rsp_if.status !== head.status) begin
          $display("%0t: status mismatch, expected %0d, got %0d",
                   $time, head.status, rsp_if.status);
          mismatches++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_taken) begin
      req_taken = 1'b0;
      if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_req = pending_q.pop_front();
        req_if.valid <= 1'b1;
        req_if.func <= next_req.func;
        req_if.in_byte <= next_req.data;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (hold_start) begin
        hold_left = HoldCycles;
        hold_start = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.func = FN_BYTE;
    req_if.in_byte = 8'h00;
    rsp_if.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_taken = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 0;
    hold_start = 1'b0;
    mismatches = 0;
    queued = 0;
    lim_dec = MaxDecodedReset;
    lim_raw = MaxRawReset;
    clear_body();
    repeat (6) @(negedge clk);
    rst_ni <= 1'b1;

    // Short bodies aimed at the edge cases, with the reset limits in place.
    push_item(FN_NEW, 8'h00);
    push_str("2\r\n");
    push_item(FN_BYTE, 8'hFF);
    push_item(FN_BYTE, 8'h00);
    push_str("\r\n0\r\n\r\n");
    push_item(FN_BYTE, 8'h41);
    push_item(FnUndef, 8'hFF);
    push_item(FN_NEW, 8'hFF);
    push_str(";");
    push_item(FN_NEW, 8'h00);
    push_str("1 2");
    push_item(FN_NEW, 8'h00);
    push_str("\n");
    push_item(FN_NEW, 8'h00);
    push_str("1\rX");
    push_item(FN_NEW, 8'h00);
    push_str("1\r\nZX");
    push_item(FN_NEW, 8'h00);
    push_str("10000000000000000");
    push_item(FN_NEW, 8'h00);
    push_str("f\r\na");
    push_item(FN_CLOSE, 8'h00);
    push_item(FN_CLOSE, 8'h00);
    drain();

    for (int p = 0; p < NumPhases; p++) begin
      set_limit(REG_MAX_DECODED, PhaseDecLimit[p]);
      set_limit(REG_MAX_RAW, PhaseRawLimit[p]);
      @(posedge clk);
      send_idle_pct = PhaseSendIdle[p];
      recv_stall_pct = PhaseRecvStall[p];
      gen_items(PhaseItems[p]);
      if (p == 0) hold_start = 1'b1;
      drain();
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/hcbd_pkg.sv
rtl/hcbd_if.sv
rtl/http_chunked_body_decoder.sv
bench/http_chunked_body_decoder_tb.sv
